[hw/rtl/tdtq_pkg.sv]
package tdtq_pkg;

  localparam int Depth = 16;
  localparam int MaxFire = 16;
  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int FireW = $clog2(MaxFire + 1);
  localparam int FifoDepth = 2;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_DEL   = 3'd1,
    CMD_QUERY = 3'd2,
    CMD_TICK  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_IDLE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  tag_id;
    logic [31:0] value;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

[hw/rtl/tdtq_front.sv]
module tdtq_front
  import tdtq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [2:0]   command,
  input  logic [7:0]   tag_id,
  input  logic [31:0]  wait_time,
  input  logic [31:0]  now,
  output logic         busy,
  output op_t          op,
  output logic         op_valid,
  input  logic         op_pop,
  output fifo_status_t fifo_status
);

  op_t                   fifo [FifoDepth];
  logic [0:0]            wr_ptr;
  logic [0:0]            rd_ptr;
  logic [1:0]            count;
  logic                  push;
  op_t                   in_op;

  // Adds carry their deadline; ticks carry the current time.
  always_comb begin
    in_op.command = command;
    in_op.tag_id = tag_id;
    if (command == CMD_ADD) begin
      in_op.value = now + wait_time;
    end else begin
      in_op.value = now;
    end
  end

  assign busy = (count == 2'(FifoDepth));
  assign push = start && !busy;
  assign op = fifo[rd_ptr];
  assign op_valid = (count != 2'd0);
  assign fifo_status.full = busy;
  assign fifo_status.empty = !op_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_op;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (op_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + 2'(push) - 2'(op_pop);
    end
  end

endmodule

[hw/rtl/tdtq_back.sv]
module tdtq_back
  import tdtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  input  logic        op_valid,
  output logic        op_pop,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic        status,
  output logic [7:0]  fired_tag,
  output logic [31:0] deadline,
  output logic        last
);

  logic [31:0]     slot_deadline [Depth];
  logic [7:0]      slot_tag [Depth];
  logic [CntW-1:0] cnt;
  state_t          state;
  state_t          state_next;
  logic [FireW-1:0] fired;

  // Per-slot match and compare terms; after_hit is a running OR over the slots.
  logic [Depth-1:0] hit;
  logic [Depth-1:0] after_hit;
  logic [Depth-1:0] le_new;
  logic             found;
  logic [31:0]      hit_dl;
  logic [CntW-1:0]  cnt_rm;
  logic [Depth-1:0] ins_before;
  logic             head_due;

  always_comb begin
    hit = '0;
    after_hit = '0;
    le_new = '0;
    hit_dl = '0;
    for (int i = 0; i < Depth; i++) begin
      hit[i] = (CntW'(i) < cnt) && (slot_tag[i] == op.tag_id);
      le_new[i] = slot_deadline[i] <= op.value;
    end
    // Tags are unique in the queue, so at most one bit of hit is set.
    for (int i = 0; i < Depth; i++) begin
      if (hit[i]) begin
        hit_dl = slot_deadline[i];
      end
      after_hit[i] = hit[i] | ((i == 0) ? 1'b0 : after_hit[(i + Depth - 1) % Depth]);
    end
    found = |hit;
    cnt_rm = cnt - CntW'(found);
    // Slot index in the compacted queue (after removal).
    for (int i = 0; i < Depth; i++) begin
      ins_before[i] = 1'b0;
    end
    for (int i = 0; i < Depth; i++) begin
      if (i < Depth - 1) begin
        ins_before[i] = (CntW'(i) < cnt_rm) &&
          (after_hit[i] ? le_new[i+1] : le_new[i]);
      end else begin
        ins_before[i] = (CntW'(i) < cnt_rm) && !after_hit[i] && le_new[i];
      end
    end
    head_due = (cnt != '0) && (slot_deadline[0] <= op.value);
  end

  logic [31:0] cd_dl [Depth];
  logic [7:0]  cd_tag [Depth];

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (after_hit[i] && i < Depth - 1) begin
        cd_dl[i] = slot_deadline[(i + 1) % Depth];
        cd_tag[i] = slot_tag[(i + 1) % Depth];
      end else begin
        cd_dl[i] = slot_deadline[i];
        cd_tag[i] = slot_tag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      fired <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && op_valid) begin
        fired <= '0;
        case (op.command)
          CMD_ADD: begin
            if (cnt_rm != CntW'(Depth)) begin
              cnt <= cnt_rm + 1'b1;
            end else begin
              cnt <= cnt_rm;
            end
          end
          CMD_DEL: cnt <= cnt_rm;
          CMD_CLEAR: cnt <= '0;
          default: ;
        endcase
      end else if (state == ST_FIRE && head_due && fired != FireW'(MaxFire)) begin
        cnt <= cnt - 1'b1;
        fired <= fired + 1'b1;
      end
    end
  end

  // Payload moves: add inserts into the compacted order, delete compacts,
  // a fire shifts the whole queue down by one.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && op_valid) begin
      if (op.command == CMD_ADD && cnt_rm != CntW'(Depth)) begin
        for (int i = 0; i < Depth; i++) begin
          if (ins_before[i]) begin
            slot_deadline[i] <= cd_dl[i];
            slot_tag[i] <= cd_tag[i];
          end else if (i == 0 || ins_before[(i + Depth - 1) % Depth]) begin
            slot_deadline[i] <= op.value;
            slot_tag[i] <= op.tag_id;
          end else begin
            slot_deadline[i] <= cd_dl[(i + Depth - 1) % Depth];
            slot_tag[i] <= cd_tag[(i + Depth - 1) % Depth];
          end
        end
      end else if (op.command == CMD_ADD || op.command == CMD_DEL) begin
        for (int i = 0; i < Depth; i++) begin
          slot_deadline[i] <= cd_dl[i];
          slot_tag[i] <= cd_tag[i];
        end
      end
    end else if (state == ST_FIRE && head_due && fired != FireW'(MaxFire)) begin
      for (int i = 0; i < Depth - 1; i++) begin
        slot_deadline[i] <= slot_deadline[i+1];
        slot_tag[i] <= slot_tag[i+1];
      end
    end
  end

  always_comb begin
    state_next = state;
    op_pop = 1'b0;
    strobe = 1'b0;
    kind = KIND_STATUS;
    status = 1'b0;
    fired_tag = '0;
    deadline = '0;
    last = 1'b0;
    case (state)
      ST_IDLE: begin
        if (op_valid) begin
          if (op.command == CMD_TICK) begin
            state_next = ST_FIRE;
          end else begin
            op_pop = 1'b1;
            strobe = 1'b1;
            last = 1'b1;
            case (op.command)
              CMD_ADD: status = (cnt_rm == CntW'(Depth));
              CMD_DEL: status = !found;
              CMD_QUERY: begin
                status = !found;
                deadline = hit_dl;
              end
              CMD_CLEAR: status = 1'b0;
              default: status = 1'b1;
            endcase
          end
        end
      end
      ST_FIRE: begin
        if (head_due && fired != FireW'(MaxFire)) begin
          strobe = 1'b1;
          kind = KIND_FIRED;
          fired_tag = slot_tag[0];
          deadline = slot_deadline[0];
          if (!(cnt > CntW'(1) && slot_deadline[1 % Depth] <= op.value) ||
              fired == FireW'(MaxFire - 1)) begin
            last = 1'b1;
            op_pop = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          // Reached only when nothing was due at all.
          strobe = 1'b1;
          kind = KIND_IDLE;
          last = 1'b1;
          op_pop = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/tagged_deadline_timer_queue.sv]
// Sorted timer queue of up to 16 tagged timers.
// Input: command, tag_id, wait_time and now are taken at a rising edge with
// start high and busy low. A two-entry command queue sits between the front,
// which computes the add deadline, and the back, which holds the sorted
// slots, so busy rises only when that queue is full.
// Output: each result appears for one cycle with strobe high; last marks the
// final result of a command. The receiver cannot stall the block.
// Flow: a command is registered in the command queue and taken from there by
// the back once it is idle. Add, delete, query and clear produce their reply
// combinationally when taken. A tick first enters the fire state and then emits
// one fired timer per cycle, up to 16, or one nothing-due result; the back
// takes no other command meanwhile. Non-tick commands thus complete at one
// item per cycle while no tick is in progress, and fired timers leave one at
// a time through the single shift-down of the slot array.
// Reset empties the queue and the command queue.
module tagged_deadline_timer_queue
  import tdtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [7:0]  tag_id,
  input  logic [31:0] wait_time,
  input  logic [31:0] now,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic        status,
  output logic [7:0]  fired_tag,
  output logic [31:0] deadline,
  output logic        last
);

  op_t          op;
  logic         op_valid;
  logic         op_pop;
  fifo_status_t fifo_status;

  tdtq_front u_front (
    .clk(clk), .rst(rst), .start(start), .command(command), .tag_id(tag_id),
    .wait_time(wait_time), .now(now), .busy(busy), .op(op),
    .op_valid(op_valid), .op_pop(op_pop), .fifo_status(fifo_status)
  );

  tdtq_back u_back (
    .clk(clk), .rst(rst), .op(op), .op_valid(op_valid), .op_pop(op_pop),
    .strobe(strobe), .kind(kind), .status(status), .fired_tag(fired_tag),
    .deadline(deadline), .last(last)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    op_pop |-> !fifo_status.empty) else $error("pop from empty queue");
  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> strobe) else $error("last without strobe");
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    op_pop == (strobe && last)) else $error("pop not tied to final result");

endmodule
